// ===== src/dap_pkg.sv =====
// Types and constants shared by the DNS answer frame parser.
// No dependencies; imported by every module of the block.
package dap_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TID     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_PORT_HIGH = 2'd1;

  localparam logic [7:0] CLIENT_PORT_HIGH_RST = 8'hE0;

  // Frame checks
  localparam int unsigned MIN_FRAME     = 70;
  localparam logic [7:0]  DNS_PORT_LO   = 8'd53;
  localparam logic [7:0]  FLAGS_MASK    = 8'h8F;
  localparam logic [7:0]  FLAGS_RESP_OK = 8'h80;
  localparam logic [7:0]  NAME_PTR_MASK = 8'hC0;
  localparam logic [7:0]  IPV4_LEN_LO   = 8'd4;

  // Header byte positions, bytes before the UDP payload start
  localparam int unsigned SRC_PORT_LO_BACK = 7;
  localparam int unsigned DST_PORT_HI_BACK = 6;
  localparam int unsigned DST_PORT_LO_BACK = 5;
  // Positions relative to the UDP payload start
  localparam int unsigned DNS_ID_LO_OFS = 1;
  localparam int unsigned DNS_FLAGS_OFS = 3;
  localparam int unsigned DNS_HDR_LEN   = 12;
  // Positions relative to the end of the answer name
  localparam int unsigned PTR_NAME_LEN  = 2;
  localparam int unsigned RDLEN_LO_OFS  = 9;
  localparam int unsigned ADDR_FIRST    = 10;
  localparam int unsigned ADDR_LAST     = 13;
  // Name scan stops this many bytes before the frame end
  localparam int unsigned SCAN_MARGIN   = 7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NAME,
    PH_SCAN,
    PH_LEN,
    PH_ADDR,
    PH_DONE
  } dap_phase_e;

  typedef enum logic [1:0] {
    ST_IGNORED   = 2'd0,
    ST_ANSWER    = 2'd1,
    ST_BAD_FLAGS = 2'd2,
    ST_NOT_IPV4  = 2'd3
  } dap_status_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FLAGS    = 2'd1,
    ERR_NOT_IPV4 = 2'd2
  } dap_err_e;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [10:0] frame_len;
    logic        last_byte;
  } dap_in_t;

  typedef struct packed {
    dap_status_e status;
    logic [31:0] answer_ip;
    logic        have_answer;
    dap_err_e    error_code;
  } dap_out_t;

  typedef struct packed {
    logic [7:0] expected_tid;
    logic [7:0] client_port_high;
    logic       clear_sticky;
  } dap_cfg_t;

endpackage

// ===== src/dap_in_reg.sv =====
// Input register of the DNS answer frame parser.
// Holds one byte transfer until the parser consumes it; uses dap_pkg.
module dap_in_reg import dap_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dap_in_t in_data_i,
  input  logic    advance_i,
  output logic    valid_o,
  output dap_in_t data_o
);

  logic    valid_q;
  dap_in_t data_q;

  assign in_stall_o = valid_q && !advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/dap_parser.sv =====
// Per-byte parse state of the DNS answer frame parser: header checks,
// answer name skip, length check, address capture and sticky flags. Uses dap_pkg.
module dap_parser import dap_pkg::*; #(
  parameter int unsigned DATA_OFFSET = 42,
  parameter int unsigned LEN_BITS    = 11
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  dap_in_t  item_i,
  input  dap_cfg_t cfg_i,
  output logic     res_valid_o,
  output dap_out_t res_o
);

  // Wide enough for any frame position plus the largest answer offset
  localparam int unsigned PW = ((LEN_BITS > 9) ? LEN_BITS : 9) + 2;
  localparam logic [PW-1:0] OFS = PW'(DATA_OFFSET);
  localparam logic [LEN_BITS-1:0] POS_MAX = '1;

  logic [LEN_BITS-1:0] pos_q, pos_d, len_q, len_d, len_in;
  logic [PW-1:0]       ans_q, ans_d, rec_q, rec_d;
  dap_phase_e          phase_q, phase_d;
  dap_status_e         verdict_q, verdict_d;
  logic [31:0]         ip_shift_q, ip_shift_d, ip_held_q, ip_held_d;
  logic                sticky_ans_q, sticky_ans_d;
  dap_err_e            sticky_err_q, sticky_err_d;

  logic [LEN_BITS+10:0] len_ext;
  logic [PW-1:0]        pos_w, len_w, b_w;
  logic [7:0]           b;
  dap_status_e          status;

  assign len_ext = {{LEN_BITS{1'b0}}, item_i.frame_len};
  assign len_in  = len_ext[LEN_BITS-1:0];

  always_comb begin
    b      = item_i.rx_byte;
    b_w    = PW'(b);
    len_d  = (pos_q == '0) ? len_in : len_q;
    pos_w  = PW'(pos_q);
    len_w  = PW'(len_d);

    pos_d        = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
    ans_d        = ans_q;
    rec_d        = rec_q;
    phase_d      = phase_q;
    verdict_d    = verdict_q;
    ip_shift_d   = ip_shift_q;
    ip_held_d    = ip_held_q;
    sticky_ans_d = sticky_ans_q;
    sticky_err_d = sticky_err_q;
    status       = ST_IGNORED;

    // Short frame, or a byte at or past the frame end, drops the frame
    if (phase_q != PH_DONE && (len_w < PW'(MIN_FRAME) || pos_w >= len_w)) begin
      phase_d   = PH_DONE;
      verdict_d = ST_IGNORED;
    end

    unique case (phase_d)
      PH_HEADER: begin
        if (pos_w == OFS - PW'(SRC_PORT_LO_BACK)) begin
          if (b != DNS_PORT_LO) begin
            phase_d   = PH_DONE;
            verdict_d = ST_IGNORED;
          end
        end else if (pos_w == OFS - PW'(DST_PORT_HI_BACK)) begin
          if (b != cfg_i.client_port_high) begin
            phase_d   = PH_DONE;
            verdict_d = ST_IGNORED;
          end
        end else if (pos_w == OFS - PW'(DST_PORT_LO_BACK)) begin
          if (b != cfg_i.expected_tid) begin
            phase_d   = PH_DONE;
            verdict_d = ST_IGNORED;
          end
        end else if (pos_w == OFS) begin
          // query length sits in the ID high byte
          ans_d = OFS + PW'(DNS_HDR_LEN) + b_w;
        end else if (pos_w == OFS + PW'(DNS_ID_LO_OFS)) begin
          if (b != cfg_i.expected_tid) begin
            phase_d   = PH_DONE;
            verdict_d = ST_IGNORED;
          end
        end else if (pos_w == OFS + PW'(DNS_FLAGS_OFS)) begin
          if ((b & FLAGS_MASK) != FLAGS_RESP_OK) begin
            phase_d   = PH_DONE;
            verdict_d = ST_BAD_FLAGS;
          end else begin
            phase_d = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (pos_w == ans_q) begin
          if ((b & NAME_PTR_MASK) != '0) begin
            rec_d   = ans_q + PW'(PTR_NAME_LEN);
            phase_d = PH_LEN;
          end else if (ans_q + PW'(SCAN_MARGIN) >= len_w) begin
            rec_d   = ans_q;
            phase_d = PH_LEN;
          end else begin
            phase_d = PH_SCAN;
          end
        end
      end
      PH_SCAN: begin
        if (b == '0) begin
          rec_d   = pos_w + 1'b1;
          phase_d = PH_LEN;
        end else if (pos_w + PW'(SCAN_MARGIN) >= len_w) begin
          rec_d   = pos_w;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (pos_w == rec_q + PW'(RDLEN_LO_OFS)) begin
          if (b != IPV4_LEN_LO) begin
            phase_d   = PH_DONE;
            verdict_d = ST_NOT_IPV4;
          end else begin
            phase_d = PH_ADDR;
          end
        end
      end
      PH_ADDR: begin
        if (pos_w >= rec_q + PW'(ADDR_FIRST)) begin
          ip_shift_d = {ip_shift_q[23:0], b};
          if (pos_w == rec_q + PW'(ADDR_LAST)) begin
            phase_d   = PH_DONE;
            verdict_d = ST_ANSWER;
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    if (item_i.last_byte) begin
      status = (phase_d == PH_DONE) ? verdict_d : ST_IGNORED;
      case (status)
        ST_ANSWER: begin
          ip_held_d    = ip_shift_d;
          sticky_ans_d = 1'b1;
        end
        ST_BAD_FLAGS: sticky_err_d = ERR_FLAGS;
        ST_NOT_IPV4:  sticky_err_d = ERR_NOT_IPV4;
        default: ;
      endcase
      pos_d      = '0;
      phase_d    = PH_HEADER;
      verdict_d  = ST_IGNORED;
      ip_shift_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      ans_q      <= '0;
      rec_q      <= '0;
      phase_q    <= PH_HEADER;
      verdict_q  <= ST_IGNORED;
      ip_shift_q <= '0;
      ip_held_q  <= '0;
    end else if (fire_i) begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      ans_q      <= ans_d;
      rec_q      <= rec_d;
      phase_q    <= phase_d;
      verdict_q  <= verdict_d;
      ip_shift_q <= ip_shift_d;
      ip_held_q  <= ip_held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_ans_q <= 1'b0;
      sticky_err_q <= ERR_NONE;
    end else if (cfg_i.clear_sticky) begin
      sticky_ans_q <= 1'b0;
      sticky_err_q <= ERR_NONE;
    end else if (fire_i) begin
      sticky_ans_q <= sticky_ans_d;
      sticky_err_q <= sticky_err_d;
    end
  end

  assign res_valid_o       = fire_i && item_i.last_byte;
  assign res_o.status      = status;
  assign res_o.answer_ip   = ip_held_d;
  assign res_o.have_answer = sticky_ans_d;
  assign res_o.error_code  = sticky_err_d;

endmodule

// ===== src/dap_out_reg.sv =====
// Result register of the DNS answer frame parser.
// Holds one status transfer until the sink takes it; uses dap_pkg.
module dap_out_reg import dap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  dap_out_t res_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dap_out_t out_data_o
);

  logic     valid_q;
  dap_out_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/dns_answer_frame_parser.sv =====
// DNS answer frame parser, top level: configuration registers and the
// input register / parser / result register chain. Uses dap_pkg and the dap_* modules.
//
// Takes a received Ethernet frame one byte per transfer and gives one status
// transfer at the frame's last byte: ignored, answer found (with the IPv4
// address), bad response flags, or a non-IPv4 answer length, together with the
// sticky answer flag and sticky error. One byte is taken every clock cycle while
// the input does not stall; the single pass of compares and the position counter
// between the input register and the result register sets that figure. A status
// is loaded into the result register when the last byte leaves the input
// register. The input stalls only while a finished status is held by the sink and
// another last byte is waiting. Writing expected_tid clears the sticky flags;
// write the registers only between frames.
module dns_answer_frame_parser import dap_pkg::*; #(
  parameter int unsigned DATA_OFFSET = 42,
  parameter int unsigned LEN_BITS    = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dap_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dap_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [7:0] tid_q, port_hi_q;
  dap_cfg_t   cfg;
  logic       item_valid, advance, res_valid;
  dap_in_t    item;
  dap_out_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q     <= '0;
      port_hi_q <= CLIENT_PORT_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EXPECTED_TID:     tid_q     <= cfg_data_i;
        CFG_CLIENT_PORT_HIGH: port_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.expected_tid     = tid_q;
  assign cfg.client_port_high = port_hi_q;
  assign cfg.clear_sticky     = cfg_we_i && (cfg_idx_i == CFG_EXPECTED_TID);

  // Non-final bytes never need the result register
  assign advance = item_valid && (!item.last_byte || !out_valid_o || !out_stall_i);

  dap_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  dap_parser #(
    .DATA_OFFSET (DATA_OFFSET),
    .LEN_BITS    (LEN_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (item),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dap_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for dns_answer_frame_parser: sends whole frames byte by byte,
// predicts each frame status and compares it with what the block reports.
// Depends on dap_pkg and the parser RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dap_pkg::*;

  localparam int DATA_OFS     = 42;
  localparam int SRC_PORT_AT  = DATA_OFS - int'(SRC_PORT_LO_BACK);
  localparam int DST_HI_AT    = DATA_OFS - int'(DST_PORT_HI_BACK);
  localparam int DST_LO_AT    = DATA_OFS - int'(DST_PORT_LO_BACK);
  localparam int DNS_ID_AT    = DATA_OFS + int'(DNS_ID_LO_OFS);
  localparam int FLAGS_AT     = DATA_OFS + int'(DNS_FLAGS_OFS);
  localparam int RANDOM_BYTES  = 1150;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum int {
    FLAW_SRC_PORT,
    FLAW_DST_HI,
    FLAW_DST_LO,
    FLAW_DNS_ID,
    FLAW_FLAGS,
    FLAW_RDLEN,
    FLAW_CUT_SHORT,
    FLAW_LEN_SHORT,
    FLAW_UNDER_MIN,
    FLAW_NONE
  } flaw_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  dap_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  dap_out_t              out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dns_answer_frame_parser #(
    .DATA_OFFSET(DATA_OFS),
    .LEN_BITS   (11)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Parser shadow state
  logic [7:0]  m_tid;
  logic [7:0]  m_port_hi;
  logic [10:0] m_pos;
  logic [10:0] m_len;
  logic [10:0] m_ans_start;
  logic [10:0] m_rec_pos;
  dap_phase_e  m_phase;
  dap_status_e m_verdict;
  logic [31:0] m_ip_shift;
  logic [31:0] m_ip_held;
  logic        m_have;
  dap_err_e    m_err;

  dap_out_t   status_due_q[$];
  logic [7:0] frame_buf[$];
  int         rdlen_at;
  int         bytes_sent = 0;
  int         fail_count = 0;
  int         cycles_run = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  task automatic clear_parser_shadow();
    m_tid       = '0;
    m_port_hi   = CLIENT_PORT_HIGH_RST;
    m_pos       = '0;
    m_len       = '0;
    m_ans_start = '0;
    m_rec_pos   = '0;
    m_phase     = PH_HEADER;
    m_verdict   = ST_IGNORED;
    m_ip_shift  = '0;
    m_ip_held   = '0;
    m_have      = 1'b0;
    m_err       = ERR_NONE;
  endtask

  function automatic void close_frame(input dap_status_e verdict);
    m_verdict = verdict;
    m_phase   = PH_DONE;
  endfunction

  // Advances the shadow parser by one byte; queues the status at a last byte.
  task automatic track_frame_byte(input dap_in_t item);
    int         k;
    int         lim;
    logic [7:0] b;
    dap_out_t   res;
    b = item.rx_byte;
    if (m_pos == '0) m_len = item.frame_len;
    k   = int'(m_pos) - DATA_OFS;
    lim = int'(m_len) - DATA_OFS - int'(SCAN_MARGIN);
    if (m_phase != PH_DONE && (m_len < MIN_FRAME || m_pos >= m_len)) close_frame(ST_IGNORED);
    case (m_phase)
      PH_HEADER: begin
        if (k == -int'(SRC_PORT_LO_BACK)) begin
          if (b != DNS_PORT_LO) close_frame(ST_IGNORED);
        end else if (k == -int'(DST_PORT_HI_BACK)) begin
          if (b != m_port_hi) close_frame(ST_IGNORED);
        end else if (k == -int'(DST_PORT_LO_BACK)) begin
          if (b != m_tid) close_frame(ST_IGNORED);
        end else if (k == 0) begin
          m_ans_start = 11'(DNS_HDR_LEN) + 11'(b);
        end else if (k == int'(DNS_ID_LO_OFS)) begin
          if (b != m_tid) close_frame(ST_IGNORED);
        end else if (k == int'(DNS_FLAGS_OFS)) begin
          if ((b & FLAGS_MASK) != FLAGS_RESP_OK) close_frame(ST_BAD_FLAGS);
          else m_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        if (k == int'(m_ans_start)) begin
          if ((b & NAME_PTR_MASK) != 8'h00) begin
            m_rec_pos = m_ans_start + 11'(PTR_NAME_LEN);
            m_phase   = PH_LEN;
          end else if (int'(m_ans_start) >= lim) begin
            m_rec_pos = m_ans_start;
            m_phase   = PH_LEN;
          end else begin
            m_phase = PH_SCAN;
          end
        end
      end
      PH_SCAN: begin
        if (b == 8'h00) begin
          m_rec_pos = 11'(k + 1);
          m_phase   = PH_LEN;
        end else if (k >= lim) begin
          m_rec_pos = 11'(k);
          m_phase   = PH_LEN;
        end
      end
      PH_LEN: begin
        if (k == int'(m_rec_pos) + int'(RDLEN_LO_OFS)) begin
          if (b != IPV4_LEN_LO) close_frame(ST_NOT_IPV4);
          else m_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (k >= int'(m_rec_pos) + int'(ADDR_FIRST)) begin
          m_ip_shift = {m_ip_shift[23:0], b};
          if (k == int'(m_rec_pos) + int'(ADDR_LAST)) close_frame(ST_ANSWER);
        end
      end
      default: ;
    endcase
    if (m_pos != 11'h7FF) m_pos = m_pos + 11'd1;
    if (item.last_byte) begin
      res.status = (m_phase == PH_DONE) ? m_verdict : ST_IGNORED;
      case (res.status)
        ST_ANSWER: begin
          m_ip_held = m_ip_shift;
          m_have    = 1'b1;
        end
        ST_BAD_FLAGS: m_err = ERR_FLAGS;
        ST_NOT_IPV4:  m_err = ERR_NOT_IPV4;
        default: ;
      endcase
      res.answer_ip   = m_ip_held;
      res.have_answer = m_have;
      res.error_code  = m_err;
      status_due_q.push_back(res);
      m_pos      = '0;
      m_phase    = PH_HEADER;
      m_verdict  = ST_IGNORED;
      m_ip_shift = '0;
    end
  endtask

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input dap_in_t item);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    track_frame_byte(item);
  endtask

  // frame_len only counts on byte zero; the other bytes carry noise there
  task automatic send_frame(input logic [10:0] flen);
    dap_in_t item;
    for (int i = 0; i < frame_buf.size(); i++) begin
      item.rx_byte   = frame_buf[i];
      item.frame_len = (i == 0) ? flen : 11'($urandom);
      item.last_byte = (i == frame_buf.size() - 1);
      send_byte(item);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_EXPECTED_TID) begin
      m_tid  = val;
      m_have = 1'b0;
      m_err  = ERR_NONE;
    end else if (idx == CFG_CLIENT_PORT_HIGH) begin
      m_port_hi = val;
    end
  endtask

  // Well-formed A-record response for the current tid and port into frame_buf.
  // name_kind 0 gives a label name, otherwise it is the pointer's top two bits.
  task automatic build_answer(input int qlen, input int name_kind, input int label_len,
                              input logic [7:0] rdlen_lo, input logic [31:0] ip,
                              input int pad);
    logic [7:0] flags;
    frame_buf.delete();
    while (frame_buf.size() < SRC_PORT_AT) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(DNS_PORT_LO);
    frame_buf.push_back(m_port_hi);
    frame_buf.push_back(m_tid);
    while (frame_buf.size() < DATA_OFS) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(8'(qlen));
    frame_buf.push_back(m_tid);
    frame_buf.push_back(8'($urandom));
    flags = FLAGS_RESP_OK | (8'($urandom) & ~FLAGS_MASK);
    frame_buf.push_back(flags);
    while (frame_buf.size() < DATA_OFS + int'(DNS_HDR_LEN) + qlen)
      frame_buf.push_back(8'($urandom));
    if (name_kind != 0) begin
      frame_buf.push_back({2'(name_kind), 6'($urandom)});
      frame_buf.push_back(8'($urandom));
    end else begin
      frame_buf.push_back({2'b00, 6'($urandom)});
      repeat (label_len - 1) frame_buf.push_back(8'($urandom_range(1, 255)));
      frame_buf.push_back(8'h00);
    end
    // type, class, ttl and length high byte
    repeat (RDLEN_LO_OFS) frame_buf.push_back(8'($urandom));
    rdlen_at = frame_buf.size();
    frame_buf.push_back(rdlen_lo);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(ip[8*i +: 8]);
    repeat (pad) frame_buf.push_back(8'($urandom));
    while (frame_buf.size() < MIN_FRAME) frame_buf.push_back(8'($urandom));
  endtask

  task automatic send_answer(input flaw_e flaw, input int qlen, input int name_kind,
                             input int label_len, input logic [31:0] ip, input int pad);
    int         flen;
    int         n;
    logic [7:0] v;
    build_answer(qlen, name_kind, label_len, IPV4_LEN_LO, ip, pad);
    flen = frame_buf.size();
    case (flaw)
      FLAW_SRC_PORT: frame_buf[SRC_PORT_AT] = frame_buf[SRC_PORT_AT] ^ 8'($urandom_range(1, 255));
      FLAW_DST_HI:   frame_buf[DST_HI_AT] = frame_buf[DST_HI_AT] ^ 8'($urandom_range(1, 255));
      FLAW_DST_LO:   frame_buf[DST_LO_AT] = frame_buf[DST_LO_AT] ^ 8'($urandom_range(1, 255));
      FLAW_DNS_ID:   frame_buf[DNS_ID_AT] = frame_buf[DNS_ID_AT] ^ 8'($urandom_range(1, 255));
      FLAW_FLAGS: begin
        do v = 8'($urandom); while ((v & FLAGS_MASK) == FLAGS_RESP_OK);
        frame_buf[FLAGS_AT] = v;
      end
      FLAW_RDLEN: begin
        do v = 8'($urandom); while (v == IPV4_LEN_LO);
        frame_buf[rdlen_at] = v;
      end
      FLAW_CUT_SHORT: begin
        // last byte arrives before the length says it should
        n = $urandom_range(1, flen - 1);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end
      FLAW_LEN_SHORT: flen = flen - $urandom_range(1, 8);
      FLAW_UNDER_MIN: flen = $urandom_range(0, MIN_FRAME - 1);
      default: ;
    endcase
    send_frame(11'(flen));
  endtask

  task automatic send_noise(input int len, input logic [10:0] flen);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    send_frame(flen);
  endtask

  task automatic send_random_answer(input flaw_e flaw);
    int qlen;
    qlen = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 255) : $urandom_range(0, 40);
    send_answer(flaw, qlen, $urandom_range(0, 3), $urandom_range(1, 24), $urandom,
                $urandom_range(0, 12));
  endtask

  task automatic randomize_registers();
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_SPARE_2 | 2'($urandom_range(0, 1)), 8'($urandom));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_EXPECTED_TID, pick_reg_value());
      write_reg(CFG_CLIENT_PORT_HIGH, pick_reg_value());
    end else begin
      write_reg(CFG_CLIENT_PORT_HIGH, pick_reg_value());
      write_reg(CFG_EXPECTED_TID, pick_reg_value());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    // shortest answer frame the block takes, with reset tid and port
    send_answer(FLAW_NONE, 0, 3, 1, $urandom, 0);
  endtask

  task automatic test_header_checks();
    send_answer(FLAW_SRC_PORT, 3, 1, 1, $urandom, 2);
    send_answer(FLAW_DST_HI, 3, 2, 1, $urandom, 2);
    send_answer(FLAW_DST_LO, 3, 0, 4, $urandom, 2);
    send_answer(FLAW_DNS_ID, 3, 3, 1, $urandom, 2);
  endtask

  task automatic test_answer_outcomes();
    send_answer(FLAW_NONE, 5, 0, 6, 32'h0000_0000, 0);
    send_answer(FLAW_NONE, 0, 2, 1, 32'hFFFF_FFFF, 3);
    send_answer(FLAW_FLAGS, 2, 1, 1, $urandom, 0);
    send_answer(FLAW_RDLEN, 2, 0, 3, $urandom, 0);
    send_answer(FLAW_NONE, 40, 1, 1, $urandom, 0);
  endtask

  task automatic test_name_forms();
    send_answer(FLAW_NONE, 1, 0, 1, $urandom, 0);
    send_answer(FLAW_NONE, 1, 0, 24, $urandom, 1);
    // name scan runs into its limit before the zero byte
    build_answer(0, 0, 20, IPV4_LEN_LO, $urandom, 0);
    send_frame(11'd80);
    // answer start already at the scan limit
    build_answer(30, 0, 5, IPV4_LEN_LO, $urandom, 0);
    send_frame(11'd91);
  endtask

  task automatic test_frame_bounds();
    build_answer(0, 3, 1, IPV4_LEN_LO, $urandom, 0);
    send_frame(11'(MIN_FRAME - 1));
    send_noise(5, 11'd0);
    send_noise(1, 11'($urandom));
    send_answer(FLAW_CUT_SHORT, 4, 0, 3, $urandom, 0);
    send_answer(FLAW_LEN_SHORT, 4, 1, 1, $urandom, 0);
    send_answer(FLAW_UNDER_MIN, 4, 2, 1, $urandom, 0);
    // answer start lands past the frame end
    build_answer(250, 3, 1, IPV4_LEN_LO, $urandom, 0);
    send_frame(11'(DATA_OFS + int'(DNS_HDR_LEN) + 250));
    // longest length, with more bytes than the position counter holds
    build_answer(2, 1, 1, IPV4_LEN_LO, $urandom, 0);
    while (frame_buf.size() < 2100) frame_buf.push_back(8'($urandom));
    send_frame(11'h7FF);
  endtask

  task automatic test_register_writes();
    write_reg(CFG_EXPECTED_TID, 8'hFF);
    write_reg(CFG_CLIENT_PORT_HIGH, 8'h00);
    send_answer(FLAW_NONE, 2, 3, 1, $urandom, 0);
    send_answer(FLAW_FLAGS, 2, 3, 1, $urandom, 0);
    write_reg(CFG_CLIENT_PORT_HIGH, 8'hFF);
    write_reg(CFG_EXPECTED_TID, 8'h00);
    send_answer(FLAW_NONE, 2, 0, 2, $urandom, 0);
    write_reg(CFG_SPARE_2, 8'($urandom));
    write_reg(CFG_SPARE_3, 8'($urandom));
    send_answer(FLAW_RDLEN, 2, 1, 1, $urandom, 0);
    // same tid again only clears the sticky flags
    write_reg(CFG_EXPECTED_TID, m_tid);
    send_answer(FLAW_DNS_ID, 2, 1, 1, $urandom, 0);
    write_reg(CFG_EXPECTED_TID, 8'($urandom));
    send_answer(FLAW_NONE, 2, 2, 1, $urandom, 0);
  endtask

  task automatic test_random_traffic();
    int frames;
    int pick;
    frames     = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (frames % 10 == 9) randomize_registers();
      else if ($urandom_range(0, 24) == 0) wait_drained();
      if ($urandom_range(0, 11) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      if (pick < 60) send_random_answer(FLAW_NONE);
      else if (pick < 90) send_random_answer(flaw_e'($urandom_range(0, int'(FLAW_NONE) - 1)));
      else send_noise($urandom_range(1, 80), 11'($urandom));
      frames++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    dap_out_t want;
    int       r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due_q.size() == 0) begin
        $error("unexpected status transfer: status %0d", out_data_o.status);
        fail_count++;
      end else begin
        want = status_due_q.pop_front();
        if (out_data_o.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.answer_ip != want.answer_ip) begin
          $error("answer_ip: expected %h, got %h", want.answer_ip, out_data_o.answer_ip);
          fail_count++;
        end
        if (out_data_o.have_answer != want.have_answer) begin
          $error("have_answer: expected %0d, got %0d", want.have_answer,
                 out_data_o.have_answer);
          fail_count++;
        end
        if (out_data_o.error_code != want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code,
                 out_data_o.error_code);
          fail_count++;
        end
      end
    end
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall_i <= 1'b0;
      end else if (r < 95) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(5, 40);
      end
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    clear_parser_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_header_checks();
    test_answer_outcomes();
    test_name_forms();
    test_frame_bounds();
    test_register_writes();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dap_pkg.sv
src/dap_in_reg.sv
src/dap_parser.sv
src/dap_out_reg.sv
src/dns_answer_frame_parser.sv
bench/testbench.sv
